// File: hdl/tpt_pkg.sv
package tpt_pkg;

    localparam int VM_BYTES_DEF  = 4 * 1024;
    localparam int RAM_BYTES_DEF = 1 * 1024;
    localparam int TLB_DEPTH_DEF = 16;

    localparam int VADDR_W    = 16;
    localparam int PADDR_W    = 10;
    localparam int OUTC_W     = 2;
    localparam int CNT_W      = 32;
    localparam int OB_W       = 4;
    localparam int TLBN_W     = 5;
    localparam int MAX_OB     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [OB_W-1:0]   OB_RST   = 4'd7;
    localparam logic [TLBN_W-1:0] TLBN_RST = 5'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TLB_ENTRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd2;

    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    localparam logic [OUTC_W-1:0] OUTC_INVALID  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_TLB_HIT  = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_PAGE_HIT = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_FAULT    = 2'd3;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_CLEAR  = 4'd1;
    localparam t_op OP_START  = 4'd2;
    localparam t_op OP_LOOK   = 4'd3;
    localparam t_op OP_SCAN   = 4'd4;
    localparam t_op OP_EVICT  = 4'd5;
    localparam t_op OP_FILL   = 4'd6;
    localparam t_op OP_TSEL   = 4'd7;
    localparam t_op OP_TSCAN  = 4'd8;
    localparam t_op OP_TWRITE = 4'd9;
    localparam t_op OP_OUT    = 4'd10;

    typedef struct packed {
        logic clr_done;
        logic invalid;
        logic tlb_hit;
        logic present;
        logic first_fault;
        logic policy;
        logic scan_done;
        logic found;
        logic tlb_free;
        logic tscan_done;
        logic out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// File: hdl/tlb_paging_translator_unit.sv
// an invalid address or a tlb hit goes from idle straight to the output state; a tlb miss with
// page hit passes look, tlb select and tlb write, with a tlb lru scan over the tlb entries in
// use only when no tlb slot is free; a page fault adds fill, and once free frames run out a page
// table scan (one page table read per cycle) and, when it finds a victim, an evict step come before the fill
// throughput: one request at a time; next request taken as soon as the result is registered
// reset: synchronous active low; then a clearing pass over all VM_BYTES page table entries
// resets the present bits, during which no request is accepted (configuration writes are taken)
module tlb_paging_translator_unit #(
    parameter int VM_BYTES  = tpt_pkg::VM_BYTES_DEF,
    parameter int RAM_BYTES = tpt_pkg::RAM_BYTES_DEF,
    parameter int TLB_DEPTH = tpt_pkg::TLB_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tpt_pkg::VADDR_W-1:0]    i_vaddr,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tpt_pkg::PADDR_W-1:0]    o_paddr,
    output logic [tpt_pkg::OUTC_W-1:0]     o_outcome,
    output logic [tpt_pkg::CNT_W-1:0]      o_access_total,
    output logic [tpt_pkg::CNT_W-1:0]      o_fault_total,
    output logic [tpt_pkg::CNT_W-1:0]      o_tlb_hit_total,
    input  logic                           i_cfg_wr_en,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import tpt_pkg::*;

    t_op  op;
    t_sts sts;

    tpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_op       (op)
    );

    tpt_datapath #(
        .VM_BYTES  (VM_BYTES),
        .RAM_BYTES (RAM_BYTES),
        .TLB_DEPTH (TLB_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_sts           (sts),
        .i_vaddr         (i_vaddr),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_paddr         (o_paddr),
        .o_outcome       (o_outcome),
        .o_access_total  (o_access_total),
        .o_fault_total   (o_fault_total),
        .o_tlb_hit_total (o_tlb_hit_total)
    );

endmodule

// File: hdl/tpt_ctrl.sv
module tpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tpt_pkg::t_sts i_sts,
    output tpt_pkg::t_op  o_op
);
    import tpt_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_EVICT  = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_TSEL   = 4'd6;
    localparam logic [3:0] S_TSCAN  = 4'd7;
    localparam logic [3:0] S_TWRITE = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = OP_START;
                    if (i_sts.invalid || i_sts.tlb_hit) n_state = S_OUT;
                    else n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_op = OP_LOOK;
                if (i_sts.present) n_state = S_TSEL;
                else if (i_sts.first_fault) n_state = S_FILL;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                o_op = OP_SCAN;
                if (i_sts.scan_done) n_state = i_sts.found ? S_EVICT : S_FILL;
            end
            S_EVICT: begin
                o_op    = OP_EVICT;
                n_state = S_FILL;
            end
            S_FILL: begin
                o_op    = OP_FILL;
                n_state = S_TSEL;
            end
            S_TSEL: begin
                o_op = OP_TSEL;
                if (i_sts.tlb_free || i_sts.policy == POL_FIFO) n_state = S_TWRITE;
                else n_state = S_TSCAN;
            end
            S_TSCAN: begin
                o_op = OP_TSCAN;
                if (i_sts.tscan_done) n_state = S_TWRITE;
            end
            S_TWRITE: begin
                o_op    = OP_TWRITE;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

endmodule

// File: hdl/tpt_datapath.sv
module tpt_datapath #(
    parameter int VM_BYTES  = tpt_pkg::VM_BYTES_DEF,
    parameter int RAM_BYTES = tpt_pkg::RAM_BYTES_DEF,
    parameter int TLB_DEPTH = tpt_pkg::TLB_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tpt_pkg::t_op                     i_op,
    output tpt_pkg::t_sts                    o_sts,
    input  logic [tpt_pkg::VADDR_W-1:0]      i_vaddr,
    input  logic                             i_cfg_wr_en,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [tpt_pkg::PADDR_W-1:0]      o_paddr,
    output logic [tpt_pkg::OUTC_W-1:0]       o_outcome,
    output logic [tpt_pkg::CNT_W-1:0]        o_access_total,
    output logic [tpt_pkg::CNT_W-1:0]        o_fault_total,
    output logic [tpt_pkg::CNT_W-1:0]        o_tlb_hit_total
);
    import tpt_pkg::*;

    localparam int PW  = (VM_BYTES > 1) ? $clog2(VM_BYTES) : 1;
    localparam int NPW = $clog2(VM_BYTES + 1);
    localparam int FW  = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
    localparam int NFW = $clog2(RAM_BYTES + 1);
    localparam int TW  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int TCW = $clog2(TLB_DEPTH + 1);

    // configuration
    logic [OB_W-1:0]   r_cfg_ob;
    logic [TLBN_W-1:0] r_cfg_tlb;
    logic              r_cfg_pol;

    // counters and pointers
    logic [CNT_W-1:0] r_access;
    logic [CNT_W-1:0] r_fault;
    logic [CNT_W-1:0] r_hits;
    logic [FW-1:0]    r_frame_fifo;
    logic [TW-1:0]    r_tlb_fifo;

    // tlb
    logic             r_tlb_valid [TLB_DEPTH];
    logic [PW-1:0]    r_tlb_page  [TLB_DEPTH];
    logic [FW-1:0]    r_tlb_frame [TLB_DEPTH];
    logic [CNT_W-1:0] r_tlb_used  [TLB_DEPTH];

    // page table
    logic             mem_present [VM_BYTES];
    logic [FW-1:0]    mem_frame   [VM_BYTES];
    logic [CNT_W-1:0] mem_used    [VM_BYTES];
    logic             r_rd_present;
    logic [FW-1:0]    r_rd_frame;
    logic [CNT_W-1:0] r_rd_used;

    // per request
    logic [PW-1:0]      r_vpn;
    logic [PADDR_W-1:0] r_off;
    logic [OB_W-1:0]    r_ob;
    logic [NPW-1:0]     r_npages;
    logic [NFW-1:0]     r_nframes;
    logic [TCW-1:0]     r_ntlb;
    logic [CNT_W-1:0]   r_now;
    logic [FW-1:0]      r_frame;
    logic [OUTC_W-1:0]  r_outcome;

    // scans
    logic [PW-1:0]    r_clr;
    logic [NPW-1:0]   r_scan_addr;
    logic [PW-1:0]    r_chk_addr;
    logic             r_chk_ok;
    logic             r_found;
    logic [PW-1:0]    r_best;
    logic [CNT_W:0]   r_best_t;
    logic [FW-1:0]    r_best_frame;
    logic [TW-1:0]    r_slot;
    logic [TW-1:0]    r_tidx;
    logic [CNT_W:0]   r_tbest_t;

    logic               r_out_valid;
    logic [PADDR_W-1:0] r_paddr;
    logic [OUTC_W-1:0]  r_out_outcome;
    logic [CNT_W-1:0]   r_out_access;
    logic [CNT_W-1:0]   r_out_fault;
    logic [CNT_W-1:0]   r_out_hits;

    logic [OB_W-1:0]    ob_in;
    logic [VADDR_W-1:0] vpn_in;
    logic [NPW-1:0]     npages_in;
    logic [NFW-1:0]     nframes_sh;
    logic [NFW-1:0]     nframes_in;
    logic [TCW-1:0]     ntlb_in;
    logic [PADDR_W-1:0] off_in;
    logic               invalid_in;
    logic [CNT_W-1:0]   now_in;
    logic               hit;
    logic [TW-1:0]      hit_idx;
    logic               tfree;
    logic [TW-1:0]      tfree_idx;
    logic [CNT_W-1:0]   fc_inc;
    logic               first_fault;
    logic [FW-1:0]      fifo_eff;
    logic [FW-1:0]      fifo_nxt;
    logic [TW-1:0]      tfifo_eff;
    logic [TW-1:0]      tfifo_nxt;
    logic               scan_more;
    logic               scan_match;
    logic               tscan_match;

    logic               pres_we;
    logic [PW-1:0]      pres_addr;
    logic               pres_data;
    logic               frame_we;
    logic               used_we;
    logic [PW-1:0]      used_addr;
    logic [CNT_W-1:0]   used_data;
    logic [PW-1:0]      rd_addr;

    always_comb begin
        ob_in      = (r_cfg_ob > OB_W'(MAX_OB)) ? OB_W'(MAX_OB) : r_cfg_ob;
        vpn_in     = i_vaddr >> ob_in;
        npages_in  = NPW'(VM_BYTES) >> ob_in;
        nframes_sh = NFW'(RAM_BYTES) >> ob_in;
        nframes_in = (nframes_sh == '0) ? NFW'(1) : nframes_sh;
        if (r_cfg_tlb == '0) ntlb_in = TCW'(1);
        else if (32'(r_cfg_tlb) > 32'(TLB_DEPTH)) ntlb_in = TCW'(TLB_DEPTH);
        else ntlb_in = TCW'(r_cfg_tlb);
        off_in     = i_vaddr[PADDR_W-1:0] & ~({PADDR_W{1'b1}} << ob_in);
        invalid_in = 32'(vpn_in) >= 32'(npages_in);
        now_in     = sat_inc(r_access);
    end

    // lowest matching entry wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < TLB_DEPTH; i++) begin
            if (!hit && 32'(i) < 32'(ntlb_in) && r_tlb_valid[i] &&
                VADDR_W'(r_tlb_page[i]) == vpn_in) begin
                hit     = 1'b1;
                hit_idx = TW'(i);
            end
        end
    end

    always_comb begin
        tfree     = 1'b0;
        tfree_idx = '0;
        for (int i = 0; i < TLB_DEPTH; i++) begin
            if (!tfree && 32'(i) < 32'(r_ntlb) && !r_tlb_valid[i]) begin
                tfree     = 1'b1;
                tfree_idx = TW'(i);
            end
        end
    end

    always_comb begin
        fc_inc      = sat_inc(r_fault);
        first_fault = fc_inc <= CNT_W'(r_nframes);
        fifo_eff    = (32'(r_frame_fifo) >= 32'(r_nframes)) ? '0 : r_frame_fifo;
        fifo_nxt    = (32'(fifo_eff) + 32'd1 >= 32'(r_nframes)) ? '0 : fifo_eff + FW'(1);
        tfifo_eff   = (32'(r_tlb_fifo) >= 32'(r_ntlb)) ? '0 : r_tlb_fifo;
        tfifo_nxt   = (32'(tfifo_eff) + 32'd1 >= 32'(r_ntlb)) ? '0 : tfifo_eff + TW'(1);
        scan_more   = 32'(r_scan_addr) < 32'(r_npages);
        if (r_cfg_pol == POL_FIFO)
            scan_match = r_chk_ok && !r_found && r_rd_present && r_rd_frame == r_frame;
        else
            scan_match = r_chk_ok && r_rd_present && {1'b0, r_rd_used} < r_best_t;
        tscan_match = r_tlb_valid[r_tidx] && {1'b0, r_tlb_used[r_tidx]} < r_tbest_t;
    end

    always_comb begin
        o_sts.clr_done    = r_clr == PW'(VM_BYTES - 1);
        o_sts.invalid     = invalid_in;
        o_sts.tlb_hit     = hit;
        o_sts.present     = r_rd_present;
        o_sts.first_fault = first_fault;
        o_sts.policy      = r_cfg_pol;
        o_sts.scan_done   = (r_cfg_pol == POL_FIFO && r_found) || (!r_chk_ok && !scan_more);
        o_sts.found       = r_found;
        o_sts.tlb_free    = tfree;
        o_sts.tscan_done  = 32'(r_tidx) + 32'd1 >= 32'(r_ntlb);
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    // page table port control
    always_comb begin
        pres_we   = 1'b0;
        pres_addr = r_vpn;
        pres_data = 1'b0;
        frame_we  = 1'b0;
        used_we   = 1'b0;
        used_addr = r_vpn;
        used_data = r_now;
        rd_addr   = r_vpn;
        case (i_op)
            OP_CLEAR: begin
                pres_we   = 1'b1;
                pres_addr = r_clr;
            end
            OP_START: begin
                rd_addr = vpn_in[PW-1:0];
                if (!invalid_in && hit) begin
                    used_we   = 1'b1;
                    used_addr = vpn_in[PW-1:0];
                    used_data = now_in;
                end
            end
            OP_LOOK: used_we = r_rd_present;
            OP_SCAN: rd_addr = r_scan_addr[PW-1:0];
            OP_EVICT: begin
                pres_we   = 1'b1;
                pres_addr = r_best;
            end
            OP_FILL: begin
                pres_we   = 1'b1;
                pres_data = 1'b1;
                frame_we  = 1'b1;
                used_we   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pres_we) mem_present[pres_addr] <= pres_data;
        if (frame_we) mem_frame[r_vpn] <= r_frame;
        if (used_we) mem_used[used_addr] <= used_data;
        r_rd_present <= mem_present[rd_addr];
        r_rd_frame   <= mem_frame[rd_addr];
        r_rd_used    <= mem_used[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ob     <= OB_RST;
            r_cfg_tlb    <= TLBN_RST;
            r_cfg_pol    <= POL_FIFO;
            r_access     <= '0;
            r_fault      <= '0;
            r_hits       <= '0;
            r_frame_fifo <= '0;
            r_tlb_fifo   <= '0;
            r_clr        <= '0;
            r_chk_ok     <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int j = 0; j < TLB_DEPTH; j++) r_tlb_valid[j] <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_OFFSET_BITS: r_cfg_ob  <= i_cfg_wdata[OB_W-1:0];
                    CFG_TLB_ENTRIES: r_cfg_tlb <= i_cfg_wdata[TLBN_W-1:0];
                    CFG_POLICY:      r_cfg_pol <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_op == OP_OUT) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            case (i_op)
                OP_CLEAR: r_clr <= r_clr + PW'(1);
                OP_START: begin
                    if (!invalid_in) begin
                        r_access <= now_in;
                        if (hit) r_hits <= sat_inc(r_hits);
                    end
                end
                OP_LOOK: begin
                    r_found  <= 1'b0;
                    r_chk_ok <= 1'b0;
                    if (!r_rd_present) begin
                        r_fault <= fc_inc;
                        if (!first_fault && r_cfg_pol == POL_FIFO) r_frame_fifo <= fifo_nxt;
                    end
                end
                OP_SCAN: begin
                    r_chk_ok <= scan_more;
                    if (scan_match) r_found <= 1'b1;
                end
                OP_EVICT: begin
                    for (int j = 0; j < TLB_DEPTH; j++)
                        if (r_tlb_valid[j] && r_tlb_page[j] == r_best) r_tlb_valid[j] <= 1'b0;
                end
                OP_TSEL: begin
                    if (!tfree && r_cfg_pol == POL_FIFO) r_tlb_fifo <= tfifo_nxt;
                end
                OP_TWRITE: r_tlb_valid[r_slot] <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_START: begin
                r_vpn     <= vpn_in[PW-1:0];
                r_off     <= off_in;
                r_ob      <= ob_in;
                r_npages  <= npages_in;
                r_nframes <= nframes_in;
                r_ntlb    <= ntlb_in;
                r_now     <= now_in;
                r_outcome <= invalid_in ? OUTC_INVALID : OUTC_TLB_HIT;
                if (!invalid_in && hit) begin
                    r_frame             <= r_tlb_frame[hit_idx];
                    r_tlb_used[hit_idx] <= now_in;
                end
            end
            OP_LOOK: begin
                r_scan_addr <= '0;
                r_best_t    <= {1'b0, r_now} + (CNT_W + 1)'(1);
                if (r_rd_present) begin
                    r_frame   <= r_rd_frame;
                    r_outcome <= OUTC_PAGE_HIT;
                end else begin
                    r_outcome <= OUTC_FAULT;
                    if (first_fault) r_frame <= FW'(r_fault);
                    else if (r_cfg_pol == POL_FIFO) r_frame <= fifo_eff;
                    else r_frame <= '0;
                end
            end
            OP_SCAN: begin
                if (scan_more) r_scan_addr <= r_scan_addr + NPW'(1);
                r_chk_addr <= r_scan_addr[PW-1:0];
                if (scan_match) begin
                    r_best       <= r_chk_addr;
                    r_best_t     <= {1'b0, r_rd_used};
                    r_best_frame <= r_rd_frame;
                end
            end
            OP_EVICT: begin
                if (r_cfg_pol == POL_LRU) r_frame <= r_best_frame;
            end
            OP_TSEL: begin
                r_tidx    <= '0;
                r_tbest_t <= {1'b0, r_now} + (CNT_W + 1)'(1);
                if (tfree) r_slot <= tfree_idx;
                else if (r_cfg_pol == POL_FIFO) r_slot <= tfifo_eff;
                else r_slot <= '0;
            end
            OP_TSCAN: begin
                if (tscan_match) begin
                    r_tbest_t <= {1'b0, r_tlb_used[r_tidx]};
                    r_slot    <= r_tidx;
                end
                r_tidx <= r_tidx + TW'(1);
            end
            OP_TWRITE: begin
                r_tlb_page[r_slot]  <= r_vpn;
                r_tlb_frame[r_slot] <= r_frame;
                r_tlb_used[r_slot]  <= r_now;
            end
            OP_OUT: begin
                r_paddr       <= (r_outcome == OUTC_INVALID) ? '0 :
                                 ((PADDR_W'(r_frame) << r_ob) | r_off);
                r_out_outcome <= r_outcome;
                r_out_access  <= r_access;
                r_out_fault   <= r_fault;
                r_out_hits    <= r_hits;
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_paddr         = r_paddr;
    assign o_outcome       = r_out_outcome;
    assign o_access_total  = r_out_access;
    assign o_fault_total   = r_out_fault;
    assign o_tlb_hit_total = r_out_hits;

endmodule
